[hdl/bcc_pkg.sv]
// ----------------------------------------------------------------------------
// bcc_pkg
// shared types and constants of the button click classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

    // counter and register widths
    localparam int TICK_W  = 16;
    localparam int CLICK_W = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // reset values of the configuration registers
    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [TICK_W-1:0] GAP_RESET      = 16'd500;
    localparam logic [TICK_W-1:0] LONG_RESET     = 16'd3000;

    // click counter saturation value
    localparam logic [CLICK_W-1:0] CLICK_MAX = 8'd255;

    // register index, taken from paddr word address
    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_GAP      = 2'd1,
        REG_LONG     = 2'd2
    } reg_idx_t;

    // one key sample beat
    typedef struct packed {
        logic key_released;
        logic hold;
    } key_t;

    // one result beat
    typedef struct packed {
        logic               clicks_done;
        logic [CLICK_W-1:0] click_count;
        logic               long_press;
    } res_t;

    // thresholds handed to the classifier
    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [TICK_W-1:0] long_ticks;
    } cfg_t;

endpackage

`default_nettype wire

[hdl/bcc_step.sv]
// ----------------------------------------------------------------------------
// bcc_step
// per-tick classifier state: hold and gap counters, pending click count
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_step
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire bcc_pkg::key_t sample,
    input  wire bcc_pkg::cfg_t cfg,
    output bcc_pkg::res_t      result
);

    logic [bcc_pkg::TICK_W-1:0]  pressed_reg, pressed_next;
    logic [bcc_pkg::TICK_W-1:0]  released_reg, released_next;
    logic [bcc_pkg::CLICK_W-1:0] clicks_reg, clicks_next;

    // next state and result of the current sample
    always_comb
    begin
        logic [bcc_pkg::CLICK_W-1:0] clicks_inc;
        logic [bcc_pkg::TICK_W-1:0]  released_inc;
        logic [bcc_pkg::TICK_W-1:0]  pressed_inc;

        pressed_next  = pressed_reg;
        released_next = released_reg;
        clicks_next   = clicks_reg;
        result        = '0;
        clicks_inc    = clicks_reg;
        released_inc  = released_reg + 16'd1;
        pressed_inc   = pressed_reg + 16'd1;

        if (!sample.hold)
        begin
            if (sample.key_released)
            begin
                // a debounced short press becomes a click on release
                if (pressed_reg > cfg.debounce_ticks && pressed_reg < cfg.long_ticks
                    && clicks_reg != bcc_pkg::CLICK_MAX)
                begin
                    clicks_inc = clicks_reg + 8'd1;
                end
                clicks_next = clicks_inc;
                // gap counter closes the sequence
                if (released_reg < cfg.gap_ticks)
                begin
                    released_next = released_inc;
                    if (released_inc == cfg.gap_ticks)
                    begin
                        if (clicks_inc != '0)
                        begin
                            result.clicks_done = 1'b1;
                            result.click_count = clicks_inc;
                        end
                        clicks_next = '0;
                    end
                end
                pressed_next = '0;
            end
            else
            begin
                // hold counter saturates at the long-press limit
                if (pressed_reg < cfg.long_ticks)
                begin
                    pressed_next = pressed_inc;
                    if (pressed_inc == cfg.long_ticks)
                    begin
                        clicks_next       = '0;
                        result.long_press = 1'b1;
                    end
                end
                released_next = '0;
            end
        end
    end

    // state registers, updated on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg  <= '0;
            released_reg <= '0;
            clicks_reg   <= '0;
        end
        else if (advance)
        begin
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            clicks_reg   <= clicks_next;
        end
    end

endmodule

`default_nettype wire

[hdl/button_click_classifier_unit.sv]
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Classifies one key sampled once per tick into click sequences and long
// presses. The result beat of each key beat appears in the result register
// in the cycle after the key beat is taken; a new key beat is taken
// every cycle as long as the result register is empty or being drained, so
// throughput is one tick per clock and only a stalled result slows intake.
// The thresholds are set over the APB port (debounce at 0x0, gap at 0x4,
// long press at 0x8) and must be written while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_classifier_unit
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // key sample channel
    input  wire logic                         key_valid,
    output logic                              key_ready,
    input  wire bcc_pkg::key_t                key_data,
    // result channel
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output bcc_pkg::res_t                     res_data,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bcc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bcc_pkg::DATA_W-1:0]   pwdata,
    output logic [bcc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    bcc_pkg::cfg_t     cfg_reg;
    bcc_pkg::res_t     step_res;
    bcc_pkg::res_t     res_data_reg;
    logic              res_valid_reg;
    logic              key_accept;
    logic              cfg_write;
    bcc_pkg::reg_idx_t reg_idx;

    // handshake
    assign key_ready  = !res_valid_reg || res_ready;
    assign key_accept = key_valid && key_ready;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_data_reg;

    // register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = bcc_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= bcc_pkg::DEBOUNCE_RESET;
            cfg_reg.gap_ticks      <= bcc_pkg::GAP_RESET;
            cfg_reg.long_ticks     <= bcc_pkg::LONG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                bcc_pkg::REG_DEBOUNCE: cfg_reg.debounce_ticks <= pwdata[15:0];
                bcc_pkg::REG_GAP:      cfg_reg.gap_ticks      <= pwdata[15:0];
                bcc_pkg::REG_LONG:     cfg_reg.long_ticks     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            bcc_pkg::REG_DEBOUNCE: prdata[15:0] = cfg_reg.debounce_ticks;
            bcc_pkg::REG_GAP:      prdata[15:0] = cfg_reg.gap_ticks;
            bcc_pkg::REG_LONG:     prdata[15:0] = cfg_reg.long_ticks;
            default:               prdata = '0;
        endcase
    end

    // classifier state and per-tick logic
    bcc_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (key_accept),
        .sample  (key_data),
        .cfg     (cfg_reg),
        .result  (step_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (key_accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_accept)
        begin
            res_data_reg <= step_res;
        end
    end

    // checks
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        key_accept |=> res_valid_reg)
        else $error("accepted beat did not fill the result register");

    a_done_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.clicks_done) |-> (res_data_reg.click_count != '0))
        else $error("sequence reported with zero clicks");

    a_done_xor_long: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_data_reg.clicks_done && res_data_reg.long_press))
        else $error("click sequence and long press on the same tick");

    a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (key_accept && key_data.hold) |=> (res_data_reg == '0))
        else $error("held tick produced an event");

endmodule

`default_nettype wire

[tb/bcc_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_result_checker
// Watches the key, result and APB channels of the click classifier. Keeps its
// own copy of the thresholds and counters, works out the result beat that
// each accepted key beat must give, and compares every result beat field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module bcc_result_checker
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              key_valid,
    input  logic              key_ready,
    input  key_t              key_data,
    input  logic              res_valid,
    input  logic              res_ready,
    input  res_t              res_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                mismatches,
    output int                pending
);

    // mirrored thresholds
    logic [TICK_W-1:0]  debounce_lim;
    logic [TICK_W-1:0]  gap_lim;
    logic [TICK_W-1:0]  long_lim;

    // mirrored counters
    logic [TICK_W-1:0]  press_run;
    logic [TICK_W-1:0]  release_run;
    logic [CLICK_W-1:0] click_tally;

    res_t               expected_events[$];
    int                 errors;

    // advance the mirrored counters by one key tick, return its event
    function automatic res_t next_click_event(key_t k);
        res_t ev;
        ev = '0;
        if (!k.hold)
        begin
            if (k.key_released)
            begin
                // end of a press: counts if past debounce and short of long
                if (press_run > debounce_lim && press_run < long_lim &&
                    click_tally != CLICK_MAX)
                begin
                    click_tally = click_tally + 1'b1;
                end
                // gap counter, ends the sequence when it hits the limit
                if (release_run < gap_lim)
                begin
                    release_run = release_run + 1'b1;
                    if (release_run == gap_lim)
                    begin
                        if (click_tally != '0)
                        begin
                            ev.clicks_done = 1'b1;
                            ev.click_count = click_tally;
                        end
                        click_tally = '0;
                    end
                end
                press_run = '0;
            end
            else
            begin
                // hold counter, saturates at the long press limit
                if (press_run < long_lim)
                begin
                    press_run = press_run + 1'b1;
                    if (press_run == long_lim)
                    begin
                        click_tally   = '0;
                        ev.long_press = 1'b1;
                    end
                end
                release_run = '0;
            end
        end
        return ev;
    endfunction

    function automatic void check_field(string name, logic [CLICK_W-1:0] want,
                                        logic [CLICK_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            debounce_lim = DEBOUNCE_RESET;
            gap_lim      = GAP_RESET;
            long_lim     = LONG_RESET;
            press_run    = '0;
            release_run  = '0;
            click_tally  = '0;
            expected_events.delete();
            errors       = 0;
        end
        else
        begin
            // result beats first: a key beat taken now cannot answer now
            if (res_valid && res_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %b/%0d/%b",
                             $time, res_data.clicks_done, res_data.click_count,
                             res_data.long_press);
                    errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("clicks_done", want.clicks_done, res_data.clicks_done);
                    check_field("click_count", want.click_count, res_data.click_count);
                    check_field("long_press", want.long_press, res_data.long_press);
                end
            end
            if (key_valid && key_ready)
                expected_events.push_back(next_click_event(key_data));
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_DEBOUNCE: debounce_lim = pwdata[TICK_W-1:0];
                    REG_GAP:      gap_lim      = pwdata[TICK_W-1:0];
                    REG_LONG:     long_lim     = pwdata[TICK_W-1:0];
                    default:      ;
                endcase
            end
        end
        mismatches <= errors;
        pending    <= expected_events.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the button click classifier: directed key sequences for the
// corner cases, a long run of click sequences, long presses and noise over
// several threshold settings, and random stalls on both channels. Checking
// is done by bcc_result_checker; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb;
    import bcc_pkg::*;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int STALL_AFTER_KEYS  = 120;
    localparam int LONG_STALL_CYCLES = 300;

    logic              clk;
    logic              rst_n;
    logic              key_valid;
    logic              key_ready;
    key_t              key_data;
    logic              res_valid;
    logic              res_ready;
    res_t              res_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                mismatches;
    int                pending;

    int                tx_idle_pct = 28;
    int                rx_idle_pct = 60;
    int                hold_pct    = 0;
    int                keys_taken  = 0;
    int                live_items  = 0;
    int                cycles      = 0;

    logic [TICK_W-1:0] cur_gap  = GAP_RESET;
    logic [TICK_W-1:0] cur_long = LONG_RESET;

    button_click_classifier_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .key_data  (key_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    bcc_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_ready  (key_ready),
        .key_data   (key_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // result sink: random stalls plus one long hold-off to back up the block
    initial
    begin : result_sink
        int stall_left;
        bit stall_done;
        stall_left = 0;
        stall_done = 1'b0;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!stall_done && keys_taken >= STALL_AFTER_KEYS)
            begin
                stall_left = LONG_STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                res_ready <= 1'b0;
                stall_left--;
            end
            else
                res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // one key beat, with random idle cycles ahead of it
    task automatic send_key(key_t k);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            key_valid <= 1'b0;
            @(posedge clk);
        end
        key_valid <= 1'b1;
        key_data  <= k;
        do
            @(posedge clk);
        while (!key_ready);
        keys_taken++;
    endtask

    // one live tick, sometimes preceded by a frozen one
    task automatic key_tick(bit rel);
        key_t k;
        if ($urandom_range(0, 99) < hold_pct)
        begin
            k.key_released = 1'($urandom_range(0, 1));
            k.hold         = 1'b1;
            send_key(k);
        end
        k.key_released = rel;
        k.hold         = 1'b0;
        send_key(k);
        live_items++;
    endtask

    task automatic hold_down(int n);
        repeat (n) key_tick(1'b0);
    endtask

    task automatic let_go(int n);
        repeat (n) key_tick(1'b1);
    endtask

    // wait until every result beat is back
    task automatic drain();
        key_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_reg(reg_idx_t idx, logic [TICK_W-1:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DATA_W-TICK_W){1'b0}}, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAP:  cur_gap  = val;
            REG_LONG: cur_long = val;
            default:  ;
        endcase
    endtask

    task automatic set_thresholds(logic [TICK_W-1:0] deb, logic [TICK_W-1:0] gap,
                                  logic [TICK_W-1:0] lng);
        set_reg(REG_DEBOUNCE, deb);
        set_reg(REG_GAP, gap);
        set_reg(REG_LONG, lng);
    endtask

    task automatic random_thresholds();
        set_thresholds(16'($urandom_range(1, 6)), 16'($urandom_range(1, 12)),
                       16'($urandom_range(2, 24)));
    endtask

    // presses and releases of random length around the thresholds, some noise
    task automatic run_sequences(int n);
        int target;
        int span;
        target = live_items + n;
        while (live_items < target)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                repeat ($urandom_range(1, 8)) key_tick(1'($urandom_range(0, 1)));
            end
            else
            begin
                span = (int'(cur_long) > 30) ? 30 : int'(cur_long) + 3;
                hold_down($urandom_range(0, span));
                span = (int'(cur_gap) > 30) ? 30 : int'(cur_gap) + 2;
                let_go($urandom_range(1, span));
            end
        end
    endtask

    // main stimulus
    initial
    begin
        rst_n     <= 1'b0;
        key_valid <= 1'b0;
        key_data  <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        set_thresholds(1, 3, 5);
        send_key('{key_released: 1'b1, hold: 1'b1});
        send_key('{key_released: 1'b0, hold: 1'b1});
        hold_down(2);
        let_go(3);        // one click, then the gap ends the sequence
        let_go(1);        // gap already reached, stays quiet
        hold_down(1);
        let_go(1);        // press not past debounce
        hold_down(6);
        let_go(1);        // long press, release counts nothing
        let_go(2);        // sequence ends with no clicks
        // long limit lowered in the middle of a press
        hold_down(3);
        set_reg(REG_LONG, 2);
        hold_down(1);
        let_go(1);
        // gap limit lowered in the middle of a release, click kept pending
        set_reg(REG_LONG, 5);
        hold_down(2);
        let_go(2);
        set_reg(REG_GAP, 1);
        let_go(1);
        set_reg(REG_GAP, 3);
        let_go(1);
        // zero limits
        set_thresholds(0, 0, 0);
        hold_down(2);
        let_go(2);
        set_thresholds(0, 2, 3);
        hold_down(1);
        let_go(2);

        // sender idles less than the receiver
        hold_pct = 8;
        set_thresholds(1, 1, 2);
        run_sequences(40);
        random_thresholds();
        run_sequences(50);
        random_thresholds();
        run_sequences(50);

        // receiver idles less than the sender
        tx_idle_pct = 60;
        rx_idle_pct = 28;
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_sequences(30);
        random_thresholds();
        run_sequences(50);
        random_thresholds();
        run_sequences(50);

        // click count saturation, one-tick presses count with zero debounce
        set_thresholds(0, 16'hFFFF, 16'hFFFF);
        repeat (257)
        begin
            hold_down(1);
            let_go(1);
        end
        set_reg(REG_GAP, 3);
        let_go(2);

        // no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_thresholds(1, 16'hFFFF, 16'hFFFF);
        run_sequences(30);
        random_thresholds();
        run_sequences(50);
        random_thresholds();
        run_sequences(50);

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
